// ----- rtl/lcdrf_pkg.sv -----
package lcdrf_pkg;

   localparam int unsigned PANEL_BITS = 10;
   localparam int unsigned COORD_BITS = 16;
   localparam int unsigned COLOR_BITS = 16;
   localparam int unsigned STEP_BITS = 4;
   localparam int unsigned STATUS_BITS = 2;
   localparam int unsigned CSR_INDEX_BITS = 1;
   localparam int unsigned PRODUCT_BITS = 2 * PANEL_BITS;
   localparam int unsigned PIXEL_COUNT_BITS_DEFAULT = 20;

   localparam logic [PANEL_BITS-1:0] PANEL_WIDTH_RESET = PANEL_BITS'(240);
   localparam logic [PANEL_BITS-1:0] PANEL_HEIGHT_RESET = PANEL_BITS'(320);

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PANEL_WIDTH = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PANEL_HEIGHT = 1'b1;

   // Input item commands.
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_NEXT = 1'b1;

   // LCD controller command bytes.
   localparam logic [7:0] LCD_COLUMN_ADDR = 8'h2A;
   localparam logic [7:0] LCD_ROW_ADDR = 8'h2B;
   localparam logic [7:0] LCD_MEMORY_WRITE = 8'h2C;

   // Start status codes.
   localparam logic [STATUS_BITS-1:0] START_NONE = 2'd0;
   localparam logic [STATUS_BITS-1:0] START_ACCEPTED = 2'd1;
   localparam logic [STATUS_BITS-1:0] START_REJECTED = 2'd2;
   localparam logic [STATUS_BITS-1:0] START_BUSY = 2'd3;

   // Header sequence steps; the pixel phase follows the last one.
   localparam logic [STEP_BITS-1:0] STEP_COL_CMD = 4'd0;
   localparam logic [STEP_BITS-1:0] STEP_XS_HI = 4'd1;
   localparam logic [STEP_BITS-1:0] STEP_XS_LO = 4'd2;
   localparam logic [STEP_BITS-1:0] STEP_XE_HI = 4'd3;
   localparam logic [STEP_BITS-1:0] STEP_XE_LO = 4'd4;
   localparam logic [STEP_BITS-1:0] STEP_ROW_CMD = 4'd5;
   localparam logic [STEP_BITS-1:0] STEP_YS_HI = 4'd6;
   localparam logic [STEP_BITS-1:0] STEP_YS_LO = 4'd7;
   localparam logic [STEP_BITS-1:0] STEP_YE_HI = 4'd8;
   localparam logic [STEP_BITS-1:0] STEP_YE_LO = 4'd9;
   localparam logic [STEP_BITS-1:0] STEP_MEM_CMD = 4'd10;
   localparam logic [STEP_BITS-1:0] STEP_PIXELS = 4'd11;

   typedef struct packed {
      logic                   byte_valid;
      logic [7:0]             out_byte;
      logic                   is_data;
      logic                   frame_end;
      logic                   fill_done;
      logic [STATUS_BITS-1:0] start_status;
   } rsp_type;

endpackage

// ----- rtl/lcd_clipped_rect_fill_stream_core.sv -----
// Rectangle fill byte stream for an 8080-style parallel LCD. A start item (cmd 0) loads a
// rectangle and an RGB565 color; it is rejected when it begins outside the panel or is empty,
// otherwise clipped to the panel edge. Each following next item (cmd 1) yields one bus byte:
// column-address command, x start/end, row-address command, y start/end (high bytes first),
// memory-write command, then high and low color bytes for every pixel. A start while a fill is
// running is ignored and reported. The block takes one item per clock cycle, but a stalled
// result register holds off only the input side; each item passes through one stage of
// logic into the result register, so its result appears the cycle after the transfer. The
// user must write panel size on the configuration port only while idle; it is not checked.
module lcd_clipped_rect_fill_stream_core #(
   parameter int unsigned PIXEL_COUNT_BITS = lcdrf_pkg::PIXEL_COUNT_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  csr_write,
   input  logic [lcdrf_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [lcdrf_pkg::PANEL_BITS-1:0]      csr_wdata,

   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_cmd,
   input  logic [lcdrf_pkg::COORD_BITS-1:0]      req_rect_x,
   input  logic [lcdrf_pkg::COORD_BITS-1:0]      req_rect_y,
   input  logic [lcdrf_pkg::COORD_BITS-1:0]      req_rect_w,
   input  logic [lcdrf_pkg::COORD_BITS-1:0]      req_rect_h,
   input  logic [lcdrf_pkg::COLOR_BITS-1:0]      req_fill_color,

   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_byte_valid,
   output logic [7:0]                            rsp_out_byte,
   output logic                                  rsp_is_data,
   output logic                                  rsp_frame_end,
   output logic                                  rsp_fill_done,
   output logic [lcdrf_pkg::STATUS_BITS-1:0]     rsp_start_status
);
   import lcdrf_pkg::*;

   localparam int unsigned WideBits =
      (PIXEL_COUNT_BITS > PRODUCT_BITS) ? PIXEL_COUNT_BITS : PRODUCT_BITS;
   localparam logic [WideBits-1:0] CountMax =
      WideBits'((64'd1 << PIXEL_COUNT_BITS) - 64'd1);

   logic [PANEL_BITS-1:0]       panel_width_ff, panel_height_ff;
   logic                        busy_ff, busy_in;
   logic [STEP_BITS-1:0]        header_step_ff, header_step_in;
   logic [PANEL_BITS-1:0]       x_start_ff, x_start_in, x_end_ff, x_end_in;
   logic [PANEL_BITS-1:0]       y_start_ff, y_start_in, y_end_ff, y_end_in;
   logic [PIXEL_COUNT_BITS-1:0] pixels_left_ff, pixels_left_in;
   logic                        low_half_next_ff, low_half_next_in;
   logic [COLOR_BITS-1:0]       color_ff, color_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   rsp_type                     rsp_ff, rsp_in;

   logic                        accept;
   logic                        reject;
   logic [PANEL_BITS-1:0]       avail_w, avail_h, clip_w, clip_h;
   logic [PRODUCT_BITS-1:0]     product;
   logic [WideBits-1:0]         product_wide;
   logic [PIXEL_COUNT_BITS-1:0] pixels_dec;

   // The result register frees up whenever its content is being taken.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign reject = (req_rect_x >= COORD_BITS'(panel_width_ff))
                || (req_rect_y >= COORD_BITS'(panel_height_ff))
                || (req_rect_w == '0) || (req_rect_h == '0);

   assign avail_w = panel_width_ff - req_rect_x[PANEL_BITS-1:0];
   assign avail_h = panel_height_ff - req_rect_y[PANEL_BITS-1:0];
   assign clip_w  = (req_rect_w > COORD_BITS'(avail_w)) ? avail_w : req_rect_w[PANEL_BITS-1:0];
   assign clip_h  = (req_rect_h > COORD_BITS'(avail_h)) ? avail_h : req_rect_h[PANEL_BITS-1:0];
   assign product = PRODUCT_BITS'(clip_w) * PRODUCT_BITS'(clip_h);
   assign product_wide = WideBits'(product);

   assign pixels_dec = (pixels_left_ff != '0)
                     ? pixels_left_ff - PIXEL_COUNT_BITS'(1) : pixels_left_ff;

   always_comb begin
      busy_in          = busy_ff;
      header_step_in   = header_step_ff;
      x_start_in       = x_start_ff;
      x_end_in         = x_end_ff;
      y_start_in       = y_start_ff;
      y_end_in         = y_end_ff;
      pixels_left_in   = pixels_left_ff;
      low_half_next_in = low_half_next_ff;
      color_in         = color_ff;
      rsp_in           = rsp_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;

      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '0;
         if (req_cmd == CMD_START) begin
            if (busy_ff) begin
               rsp_in.start_status = START_BUSY;
            end else if (reject) begin
               rsp_in.start_status = START_REJECTED;
            end else begin
               rsp_in.start_status = START_ACCEPTED;
               x_start_in       = req_rect_x[PANEL_BITS-1:0];
               x_end_in         = req_rect_x[PANEL_BITS-1:0] + clip_w - PANEL_BITS'(1);
               y_start_in       = req_rect_y[PANEL_BITS-1:0];
               y_end_in         = req_rect_y[PANEL_BITS-1:0] + clip_h - PANEL_BITS'(1);
               pixels_left_in   = (product_wide > CountMax)
                                ? PIXEL_COUNT_BITS'(CountMax)
                                : PIXEL_COUNT_BITS'(product_wide);
               color_in         = req_fill_color;
               low_half_next_in = 1'b0;
               header_step_in   = STEP_COL_CMD;
               busy_in          = 1'b1;
            end
         end else if (busy_ff) begin
            rsp_in.byte_valid = 1'b1;
            rsp_in.is_data    = 1'b1;
            if (header_step_ff < STEP_PIXELS) begin
               header_step_in = header_step_ff + STEP_BITS'(1);
               case (header_step_ff)
                  STEP_COL_CMD: begin
                     rsp_in.out_byte  = LCD_COLUMN_ADDR;
                     rsp_in.is_data   = 1'b0;
                     rsp_in.frame_end = 1'b1;
                  end
                  STEP_XS_HI: rsp_in.out_byte = 8'(x_start_ff >> 8);
                  STEP_XS_LO: rsp_in.out_byte = x_start_ff[7:0];
                  STEP_XE_HI: rsp_in.out_byte = 8'(x_end_ff >> 8);
                  STEP_XE_LO: begin
                     rsp_in.out_byte  = x_end_ff[7:0];
                     rsp_in.frame_end = 1'b1;
                  end
                  STEP_ROW_CMD: begin
                     rsp_in.out_byte  = LCD_ROW_ADDR;
                     rsp_in.is_data   = 1'b0;
                     rsp_in.frame_end = 1'b1;
                  end
                  STEP_YS_HI: rsp_in.out_byte = 8'(y_start_ff >> 8);
                  STEP_YS_LO: rsp_in.out_byte = y_start_ff[7:0];
                  STEP_YE_HI: rsp_in.out_byte = 8'(y_end_ff >> 8);
                  STEP_YE_LO: begin
                     rsp_in.out_byte  = y_end_ff[7:0];
                     rsp_in.frame_end = 1'b1;
                  end
                  default: begin
                     rsp_in.out_byte  = LCD_MEMORY_WRITE;
                     rsp_in.is_data   = 1'b0;
                     rsp_in.frame_end = 1'b1;
                  end
               endcase
            end else if (!low_half_next_ff) begin
               low_half_next_in = 1'b1;
               rsp_in.out_byte  = color_ff[15:8];
            end else begin
               low_half_next_in = 1'b0;
               pixels_left_in   = pixels_dec;
               rsp_in.out_byte  = color_ff[7:0];
               if (pixels_dec == '0) begin
                  busy_in          = 1'b0;
                  header_step_in   = STEP_COL_CMD;
                  rsp_in.frame_end = 1'b1;
                  rsp_in.fill_done = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         panel_width_ff   <= PANEL_WIDTH_RESET;
         panel_height_ff  <= PANEL_HEIGHT_RESET;
         busy_ff          <= 1'b0;
         header_step_ff   <= STEP_COL_CMD;
         x_start_ff       <= '0;
         x_end_ff         <= '0;
         y_start_ff       <= '0;
         y_end_ff         <= '0;
         pixels_left_ff   <= '0;
         low_half_next_ff <= 1'b0;
         color_ff         <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_write && csr_index == CSR_PANEL_WIDTH) begin
            panel_width_ff <= csr_wdata;
         end
         if (csr_write && csr_index == CSR_PANEL_HEIGHT) begin
            panel_height_ff <= csr_wdata;
         end
         busy_ff          <= busy_in;
         header_step_ff   <= header_step_in;
         x_start_ff       <= x_start_in;
         x_end_ff         <= x_end_in;
         y_start_ff       <= y_start_in;
         y_end_ff         <= y_end_in;
         pixels_left_ff   <= pixels_left_in;
         low_half_next_ff <= low_half_next_in;
         color_ff         <= color_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_byte_valid   = rsp_ff.byte_valid;
   assign rsp_out_byte     = rsp_ff.out_byte;
   assign rsp_is_data      = rsp_ff.is_data;
   assign rsp_frame_end    = rsp_ff.frame_end;
   assign rsp_fill_done    = rsp_ff.fill_done;
   assign rsp_start_status = rsp_ff.start_status;

endmodule

// ----- test/lcd_clipped_rect_fill_stream_core_tb.sv -----
module lcd_clipped_rect_fill_stream_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lcdrf_pkg::*;

   localparam int unsigned PIXEL_COUNT_BITS = PIXEL_COUNT_BITS_DEFAULT;
   localparam int unsigned HOLD_AT_RESULT = 300;
   localparam int unsigned HOLD_CYCLES = 120;
   localparam int unsigned PHASE_ITEMS = 290;

   typedef struct packed {
      logic                  cmd;
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS-1:0] w;
      logic [COORD_BITS-1:0] h;
      logic [COLOR_BITS-1:0] color;
   } fill_item_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_write = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_PANEL_WIDTH;
   logic [PANEL_BITS-1:0]     csr_wdata = '0;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_cmd = CMD_NEXT;
   logic [COORD_BITS-1:0]     req_rect_x = '0;
   logic [COORD_BITS-1:0]     req_rect_y = '0;
   logic [COORD_BITS-1:0]     req_rect_w = '0;
   logic [COORD_BITS-1:0]     req_rect_h = '0;
   logic [COLOR_BITS-1:0]     req_fill_color = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_byte_valid;
   logic [7:0]                rsp_out_byte;
   logic                      rsp_is_data;
   logic                      rsp_frame_end;
   logic                      rsp_fill_done;
   logic [STATUS_BITS-1:0]    rsp_start_status;

   lcd_clipped_rect_fill_stream_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_rect_x       (req_rect_x),
      .req_rect_y       (req_rect_y),
      .req_rect_w       (req_rect_w),
      .req_rect_h       (req_rect_h),
      .req_fill_color   (req_fill_color),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_is_data      (rsp_is_data),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_fill_done    (rsp_fill_done),
      .rsp_start_status (rsp_start_status)
   );

   always #5ns clock = ~clock;

   fill_item_type pending_items[$];
   rsp_type       expected_bytes[$];
   int unsigned   items_queued = 0;
   int unsigned   results_seen = 0;
   int unsigned   error_count = 0;
   int unsigned   send_wait = 0;
   int unsigned   recv_wait = 0;
   bit            send_calm = 1'b0;
   bit            recv_calm = 1'b0;

   // Predictor state: panel size and the fill in progress.
   logic [PANEL_BITS-1:0]       panel_cols = PANEL_WIDTH_RESET;
   logic [PANEL_BITS-1:0]       panel_rows = PANEL_HEIGHT_RESET;
   logic                        fill_busy = 1'b0;
   logic [STEP_BITS-1:0]        fill_step = STEP_COL_CMD;
   logic [PANEL_BITS-1:0]       win_x_first = '0;
   logic [PANEL_BITS-1:0]       win_x_last = '0;
   logic [PANEL_BITS-1:0]       win_y_first = '0;
   logic [PANEL_BITS-1:0]       win_y_last = '0;
   logic [PIXEL_COUNT_BITS-1:0] pixels_to_go = '0;
   logic                        low_byte_next = 1'b0;
   logic [COLOR_BITS-1:0]       fill_rgb = '0;

   function automatic rsp_type predict_bus_byte(input fill_item_type it);
      rsp_type     r;
      logic [31:0] cols;
      logic [31:0] rows;
      logic [63:0] area;
      r = '0;
      if (it.cmd == CMD_START) begin
         if (fill_busy) begin
            r.start_status = START_BUSY;
         end else if (it.x >= panel_cols || it.y >= panel_rows || it.w == 0 || it.h == 0) begin
            r.start_status = START_REJECTED;
         end else begin
            cols = (32'(it.x) + 32'(it.w) > 32'(panel_cols)) ? 32'(panel_cols) - 32'(it.x)
                                                             : 32'(it.w);
            rows = (32'(it.y) + 32'(it.h) > 32'(panel_rows)) ? 32'(panel_rows) - 32'(it.y)
                                                             : 32'(it.h);
            win_x_first = it.x[PANEL_BITS-1:0];
            win_x_last = PANEL_BITS'(32'(it.x) + cols - 1);
            win_y_first = it.y[PANEL_BITS-1:0];
            win_y_last = PANEL_BITS'(32'(it.y) + rows - 1);
            area = 64'(cols) * 64'(rows);
            // A pixel count wider than the counter saturates.
            pixels_to_go = (area > 64'({PIXEL_COUNT_BITS{1'b1}})) ? {PIXEL_COUNT_BITS{1'b1}}
                                                                  : PIXEL_COUNT_BITS'(area);
            fill_rgb = it.color;
            low_byte_next = 1'b0;
            fill_step = STEP_COL_CMD;
            fill_busy = 1'b1;
            r.start_status = START_ACCEPTED;
         end
         return r;
      end
      if (!fill_busy) return r;
      r.byte_valid = 1'b1;
      r.is_data = 1'b1;
      if (fill_step < STEP_PIXELS) begin
         case (fill_step)
            STEP_COL_CMD: begin
               r.out_byte = LCD_COLUMN_ADDR;
               r.is_data = 1'b0;
               r.frame_end = 1'b1;
            end
            STEP_XS_HI: r.out_byte = 8'(win_x_first >> 8);
            STEP_XS_LO: r.out_byte = win_x_first[7:0];
            STEP_XE_HI: r.out_byte = 8'(win_x_last >> 8);
            STEP_XE_LO: begin
               r.out_byte = win_x_last[7:0];
               r.frame_end = 1'b1;
            end
            STEP_ROW_CMD: begin
               r.out_byte = LCD_ROW_ADDR;
               r.is_data = 1'b0;
               r.frame_end = 1'b1;
            end
            STEP_YS_HI: r.out_byte = 8'(win_y_first >> 8);
            STEP_YS_LO: r.out_byte = win_y_first[7:0];
            STEP_YE_HI: r.out_byte = 8'(win_y_last >> 8);
            STEP_YE_LO: begin
               r.out_byte = win_y_last[7:0];
               r.frame_end = 1'b1;
            end
            default: begin
               r.out_byte = LCD_MEMORY_WRITE;
               r.is_data = 1'b0;
               r.frame_end = 1'b1;
            end
         endcase
         fill_step = fill_step + 1'b1;
      end else if (!low_byte_next) begin
         low_byte_next = 1'b1;
         r.out_byte = fill_rgb[15:8];
      end else begin
         low_byte_next = 1'b0;
         r.out_byte = fill_rgb[7:0];
         if (pixels_to_go != 0) pixels_to_go = pixels_to_go - 1'b1;
         if (pixels_to_go == 0) begin
            fill_busy = 1'b0;
            fill_step = STEP_COL_CMD;
            r.frame_end = 1'b1;
            r.fill_done = 1'b1;
         end
      end
      return r;
   endfunction

   function automatic int unsigned bytes_to_finish();
      if (!fill_busy) return 0;
      if (fill_step < STEP_PIXELS) return (STEP_PIXELS - fill_step) + 2 * pixels_to_go;
      return 2 * pixels_to_go - (low_byte_next ? 1 : 0);
   endfunction

   function automatic int unsigned draw_wait(input bit calm);
      if (calm || $urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 16);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t: result %0d mismatch, %s", $time, results_seen, msg);
      error_count++;
   endtask

   task automatic compare_field(input string name, input logic [7:0] got, input logic [7:0] want);
      if (got !== want) report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
   endtask

   task automatic check_bus_byte(input rsp_type got);
      rsp_type want;
      if (expected_bytes.size() == 0) begin
         report_mismatch("result arrived with nothing expected");
         return;
      end
      want = expected_bytes.pop_front();
      compare_field("byte_valid", 8'(got.byte_valid), 8'(want.byte_valid));
      compare_field("out_byte", got.out_byte, want.out_byte);
      compare_field("is_data", 8'(got.is_data), 8'(want.is_data));
      compare_field("frame_end", 8'(got.frame_end), 8'(want.frame_end));
      compare_field("fill_done", 8'(got.fill_done), 8'(want.fill_done));
      compare_field("start_status", 8'(got.start_status), 8'(want.start_status));
   endtask

   // Request driver: the payload only moves on after a transfer or while idle.
   always @(posedge clock) begin : drive_requests
      fill_item_type it;
      if (reset) begin
         req_valid <= 1'b0;
         send_wait = 0;
      end else begin
         if (req_valid && !req_stall) begin
            it = '{req_cmd, req_rect_x, req_rect_y, req_rect_w, req_rect_h, req_fill_color};
            expected_bytes.push_back(predict_bus_byte(it));
            if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
            send_wait = draw_wait(send_calm);
         end
         if (!req_valid || !req_stall) begin
            if (send_wait == 0 && pending_items.size() != 0) begin
               it = pending_items.pop_front();
               req_cmd <= it.cmd;
               req_rect_x <= it.x;
               req_rect_y <= it.y;
               req_rect_w <= it.w;
               req_rect_h <= it.h;
               req_fill_color <= it.color;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
               if (send_wait != 0) send_wait--;
            end
         end
      end
   end

   // Result monitor; once in the run it holds off long enough to back up the input.
   always @(posedge clock) begin : take_results
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_wait = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_bus_byte(rsp_type'({rsp_byte_valid, rsp_out_byte, rsp_is_data,
                                      rsp_frame_end, rsp_fill_done, rsp_start_status}));
            results_seen++;
            if (results_seen == HOLD_AT_RESULT) begin
               recv_wait = HOLD_CYCLES;
            end else begin
               if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
               recv_wait = draw_wait(recv_calm);
            end
         end
         if (recv_wait != 0) begin
            rsp_stall <= 1'b1;
            recv_wait--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic push_item(input logic cmd, input int unsigned x, input int unsigned y,
                            input int unsigned w, input int unsigned h, input int unsigned color);
      pending_items.push_back('{cmd, 16'(x), 16'(y), 16'(w), 16'(h), 16'(color)});
      items_queued++;
   endtask

   task automatic push_next();
      push_item(CMD_NEXT, $urandom_range(0, 65535), $urandom_range(0, 65535),
                $urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 65535));
   endtask

   // The left column lies beyond any panel, so an idle block always rejects it.
   task automatic push_wild_start();
      push_item(CMD_START, $urandom_range(1024, 65535), $urandom_range(0, 65535),
                $urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 65535));
   endtask

   task automatic write_panel(input logic [CSR_INDEX_BITS-1:0] index,
                              input logic [PANEL_BITS-1:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      if (index == CSR_PANEL_WIDTH) panel_cols = value;
      else panel_rows = value;
   endtask

   task automatic settle();
      do @(negedge clock);
      while (pending_items.size() != 0 || req_valid || expected_bytes.size() != 0);
      repeat (3) @(posedge clock);
   endtask

   // One fill with random content, sometimes cut short or interrupted by a start.
   task automatic queue_fill(input int unsigned pw, input int unsigned ph);
      int unsigned x, y, w, h, cols, rows, stream_len, busy_at, k;
      x = $urandom_range(0, pw - 1);
      w = $urandom_range(1, 5);
      if ($urandom_range(0, 3) == 0) begin
         x = pw - $urandom_range(1, (pw < 4) ? pw : 4);
         w = $urandom_range(1, 65535);
      end
      y = $urandom_range(0, ph - 1);
      h = $urandom_range(1, 5);
      if ($urandom_range(0, 3) == 0) begin
         y = ph - $urandom_range(1, (ph < 4) ? ph : 4);
         h = $urandom_range(1, 65535);
      end
      push_item(CMD_START, x, y, w, h, $urandom_range(0, 65535));
      cols = (x + w > pw) ? pw - x : w;
      rows = (y + h > ph) ? ph - y : h;
      stream_len = 11 + 2 * cols * rows;
      if ($urandom_range(0, 7) == 0) stream_len = $urandom_range(1, stream_len - 1);
      busy_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, stream_len - 1) : stream_len;
      for (k = 0; k < stream_len; k++) begin
         if (k == busy_at) push_wild_start();
         push_next();
      end
      case ($urandom_range(0, 9))
         0: push_next();
         1: push_wild_start();
         2: push_item(CMD_START, $urandom_range(0, pw - 1), $urandom_range(0, ph - 1), 0,
                      $urandom_range(0, 65535), $urandom_range(0, 65535));
         3: push_item(CMD_START, $urandom_range(0, pw - 1), $urandom_range(0, ph - 1),
                      $urandom_range(0, 65535), 0, $urandom_range(0, 65535));
         default: ;
      endcase
   endtask

   task automatic run_phase(input int unsigned pw, input int unsigned ph);
      int unsigned target;
      int unsigned k;
      write_panel(CSR_PANEL_WIDTH, PANEL_BITS'(pw));
      write_panel(CSR_PANEL_HEIGHT, PANEL_BITS'(ph));
      target = items_queued + PHASE_ITEMS;
      while (items_queued < target) queue_fill(pw, ph);
      settle();
      // Run out any fill that was cut short so the next phase starts idle.
      k = bytes_to_finish();
      repeat (k) push_next();
      settle();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset panel of 240 by 320.
      push_next();
      push_item(CMD_START, 0, 0, 0, 7, 16'h1234);
      push_item(CMD_START, 0, 0, 7, 0, 16'h1234);
      push_item(CMD_START, 240, 0, 1, 1, 16'h1234);
      push_item(CMD_START, 0, 320, 1, 1, 16'h1234);
      // Bottom-right pixel with the largest size, clipped to one pixel.
      push_item(CMD_START, 239, 319, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      push_item(CMD_START, 0, 0, 1, 1, 16'h0000);
      repeat (14) push_next();
      settle();

      // A panel with no columns takes no rectangle at all.
      write_panel(CSR_PANEL_WIDTH, '0);
      write_panel(CSR_PANEL_HEIGHT, PANEL_BITS'(1023));
      push_item(CMD_START, 0, 0, 1, 1, 16'h00FF);
      push_next();
      settle();

      run_phase(1023, 1023);
      run_phase(1, 1);
      run_phase(1023, 1);
      run_phase(1, 1023);
      run_phase($urandom_range(2, 64), $urandom_range(2, 64));
      run_phase($urandom_range(2, 1023), $urandom_range(2, 1023));

      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #4ms;
      $display("timeout with %0d results still expected", expected_bytes.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/lcdrf_pkg.sv
rtl/lcd_clipped_rect_fill_stream_core.sv
test/lcd_clipped_rect_fill_stream_core_tb.sv
